### rtl/rrts_pkg.sv
// Package for the round-robin task scheduler.
// Holds queue sizing, payload structs, queue entry layout and event codes.
// No dependencies.
package rrts_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int TIME_W      = 32;
   localparam int STEP_W      = $clog2(TIME_W);

   localparam logic [QCNT_W-1:0]  QCNT_FULL = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QADDR_W-1:0] QADDR_LAST = QADDR_W'(QUEUE_DEPTH - 1);

   localparam logic MODE_ADMIT = 1'b0;
   localparam logic MODE_TICK  = 1'b1;

   localparam logic [2:0] EV_ADMITTED = 3'd0;
   localparam logic [2:0] EV_REJECTED = 3'd1;
   localparam logic [2:0] EV_IDLE     = 3'd2;
   localparam logic [2:0] EV_RAN      = 3'd3;
   localparam logic [2:0] EV_COMPLETE = 3'd4;
   localparam logic [2:0] EV_PREEMPT  = 3'd5;

   typedef struct packed {
      logic        mode;
      logic [7:0]  task_id;
      logic [15:0] burst;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  task_id_out;
      logic [31:0] time_now;
      logic [15:0] burst_out;
      logic [31:0] arrival_out;
      logic [31:0] waiting_out;
      logic [4:0]  ready_count;
      logic        all_done;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [15:0] remaining;
      logic [15:0] burst;
      logic [31:0] arrival;
      logic [31:0] waiting;
   } entry_type;

endpackage

### rtl/round_robin_task_scheduler_top.sv
// Round-robin task scheduler top level: ready queue memory, running task,
// serial remainder unit for the quantum check and the control sequencer.
// Depends on rrts_pkg.
//
//   channel  direction  handshake                     payload
//   req      in         req_valid / req_stall         rrts_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall         rrts_pkg::rsp_type
//   csr      in         csr_write_en                  csr_write_data (time_quantum)
//
// Admit transactions and idle ticks go straight to the result state. Other ticks run the
// bit-serial remainder unit, load the head task when none is running, then age every queued
// task through the queue's single read and write port, and decide and register the result.
// Reset is synchronous; it empties the queue, clears the running task and time.
// A stalled result holds in the output register while the next transaction is taken.
module round_robin_task_scheduler_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rrts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rrts_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [15:0]       csr_write_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_MOD    = 3'd1;
   localparam logic [2:0] ST_POP_RD = 3'd2;
   localparam logic [2:0] ST_POP_LD = 3'd3;
   localparam logic [2:0] ST_AGE    = 3'd4;
   localparam logic [2:0] ST_DECIDE = 3'd5;
   localparam logic [2:0] ST_FIN    = 3'd6;

   rrts_pkg::entry_type queue_mem_ff [rrts_pkg::QUEUE_DEPTH];
   rrts_pkg::entry_type mem_rdata_ff;
   logic                mem_we;
   logic [rrts_pkg::QADDR_W-1:0] mem_waddr;
   logic [rrts_pkg::QADDR_W-1:0] mem_raddr;
   rrts_pkg::entry_type mem_wdata;

   logic [2:0] state_ff, state_in;
   logic [15:0] quantum_ff;
   logic [rrts_pkg::QADDR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [rrts_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic        run_valid_ff, run_valid_in;
   rrts_pkg::entry_type run_ff, run_in;
   logic [31:0] time_ff, time_in;

   logic [16:0] mod_rem_ff, mod_rem_in;
   logic [31:0] mod_div_ff, mod_div_in;
   logic [rrts_pkg::STEP_W-1:0] mod_step_ff, mod_step_in;
   logic [16:0] mod_shift;

   logic [rrts_pkg::QCNT_W-1:0]  age_idx_ff, age_idx_in;
   logic [rrts_pkg::QADDR_W-1:0] age_ptr_ff, age_ptr_in;
   logic [rrts_pkg::QADDR_W-1:0] age_waddr_ff, age_waddr_in;
   logic        age_pend_ff, age_pend_in;

   logic [2:0]  ev_ff, ev_in;
   logic [7:0]  id_hold_ff, id_hold_in;
   logic [15:0] rem_dec;
   logic        is_complete;

   logic        rsp_valid_ff, rsp_valid_in;
   rrts_pkg::rsp_type rsp_data_ff, rsp_data_in;

   function automatic logic [rrts_pkg::QADDR_W-1:0] ptr_inc(
      input logic [rrts_pkg::QADDR_W-1:0] p);
      ptr_inc = (p == rrts_pkg::QADDR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mod_shift   = {mod_rem_ff[15:0], mod_div_ff[31]};
   assign rem_dec     = (run_ff.remaining != 16'd0) ? run_ff.remaining - 16'd1 : 16'd0;
   assign is_complete = (ev_ff == rrts_pkg::EV_COMPLETE);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      run_valid_in = run_valid_ff;
      run_in       = run_ff;
      time_in      = time_ff;
      mod_rem_in   = mod_rem_ff;
      mod_div_in   = mod_div_ff;
      mod_step_in  = mod_step_ff;
      age_idx_in   = age_idx_ff;
      age_ptr_in   = age_ptr_ff;
      age_waddr_in = age_waddr_ff;
      age_pend_in  = 1'b0;
      ev_in        = ev_ff;
      id_hold_in   = id_hold_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = tail_ff;
      mem_wdata    = run_ff;
      mem_raddr    = age_ptr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.mode == rrts_pkg::MODE_ADMIT) begin
                  id_hold_in = req_data.task_id;
                  if (count_ff >= rrts_pkg::QCNT_FULL) begin
                     ev_in = rrts_pkg::EV_REJECTED;
                  end else begin
                     mem_we            = 1'b1;
                     mem_wdata.task_id = req_data.task_id;
                     mem_wdata.remaining = req_data.burst;
                     mem_wdata.burst   = req_data.burst;
                     mem_wdata.arrival = time_ff + 32'd1;
                     mem_wdata.waiting = 32'd0;
                     tail_in           = ptr_inc(tail_ff);
                     count_in          = count_ff + 1'b1;
                     ev_in             = rrts_pkg::EV_ADMITTED;
                  end
                  state_in = ST_FIN;
               end else begin
                  time_in = time_ff + 32'd1;
                  if (!run_valid_ff && count_ff == '0) begin
                     ev_in      = rrts_pkg::EV_IDLE;
                     id_hold_in = 8'd0;
                     state_in   = ST_FIN;
                  end else begin
                     mod_rem_in  = '0;
                     mod_div_in  = time_ff + 32'd1;
                     mod_step_in = '0;
                     state_in    = ST_MOD;
                  end
               end
            end
         end
         ST_MOD: begin
            mod_rem_in  = (mod_shift >= {1'b0, quantum_ff}) ?
                          mod_shift - {1'b0, quantum_ff} : mod_shift;
            mod_div_in  = {mod_div_ff[30:0], 1'b0};
            mod_step_in = mod_step_ff + 1'b1;
            if (mod_step_ff == rrts_pkg::STEP_W'(rrts_pkg::TIME_W - 1)) begin
               age_idx_in = '0;
               age_ptr_in = head_ff;
               state_in   = run_valid_ff ? ST_AGE : ST_POP_RD;
            end
         end
         ST_POP_RD: begin
            mem_raddr = head_ff;
            state_in  = ST_POP_LD;
         end
         ST_POP_LD: begin
            run_in       = mem_rdata_ff;
            run_valid_in = 1'b1;
            head_in      = ptr_inc(head_ff);
            count_in     = count_ff - 1'b1;
            age_idx_in   = '0;
            age_ptr_in   = ptr_inc(head_ff);
            state_in     = ST_AGE;
         end
         ST_AGE: begin
            if (age_idx_ff != count_ff) begin
               mem_raddr    = age_ptr_ff;
               age_idx_in   = age_idx_ff + 1'b1;
               age_ptr_in   = ptr_inc(age_ptr_ff);
               age_waddr_in = age_ptr_ff;
               age_pend_in  = 1'b1;
            end else if (!age_pend_ff) begin
               state_in = ST_DECIDE;
            end
            if (age_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = age_waddr_ff;
               mem_wdata = mem_rdata_ff;
               if (mem_rdata_ff.waiting != 32'hFFFF_FFFF) begin
                  mem_wdata.waiting = mem_rdata_ff.waiting + 32'd1;
               end
            end
         end
         ST_DECIDE: begin
            run_in.remaining = rem_dec;
            id_hold_in       = run_ff.task_id;
            if (rem_dec == 16'd0) begin
               ev_in        = rrts_pkg::EV_COMPLETE;
               run_valid_in = 1'b0;
            end else if (quantum_ff != 16'd0 && mod_rem_ff == '0 && count_ff != '0 &&
                         count_ff < rrts_pkg::QCNT_FULL) begin
               mem_we              = 1'b1;
               mem_wdata.remaining = rem_dec;
               tail_in             = ptr_inc(tail_ff);
               count_in            = count_ff + 1'b1;
               run_valid_in        = 1'b0;
               ev_in               = rrts_pkg::EV_PREEMPT;
            end else begin
               ev_in = rrts_pkg::EV_RAN;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.event_res   = ev_ff;
               rsp_data_in.task_id_out = id_hold_ff;
               rsp_data_in.time_now    = time_ff;
               rsp_data_in.burst_out   = is_complete ? run_ff.burst : 16'd0;
               rsp_data_in.arrival_out = is_complete ? run_ff.arrival : 32'd0;
               rsp_data_in.waiting_out = is_complete ? run_ff.waiting : 32'd0;
               rsp_data_in.ready_count = 5'(count_ff);
               rsp_data_in.all_done    = (count_ff == '0) && !run_valid_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem_ff[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= queue_mem_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         quantum_ff   <= 16'd4;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         run_valid_ff <= 1'b0;
         run_ff       <= '0;
         time_ff      <= '0;
         age_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_en) begin
            quantum_ff <= csr_write_data;
         end
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         run_valid_ff <= run_valid_in;
         run_ff       <= run_in;
         time_ff      <= time_in;
         age_pend_ff  <= age_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_rem_ff   <= mod_rem_in;
      mod_div_ff   <= mod_div_in;
      mod_step_ff  <= mod_step_in;
      age_idx_ff   <= age_idx_in;
      age_ptr_ff   <= age_ptr_in;
      age_waddr_ff <= age_waddr_in;
      ev_ff        <= ev_in;
      id_hold_ff   <= id_hold_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

### rtl/rrts_checker.sv
// Port-level checker for the round-robin task scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_task_scheduler_top.
module rrts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rrts_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction dropped or changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req transaction accepted while previous one in flight");

   a_done_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.all_done |-> rsp_data.ready_count == 5'd0)
      else $error("all_done reported with tasks queued");

   a_idle_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res == rrts_pkg::EV_IDLE |->
         rsp_data.all_done && rsp_data.task_id_out == 8'd0)
      else $error("idle tick reported with work present");

   a_stats_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.event_res != rrts_pkg::EV_COMPLETE |->
         rsp_data.burst_out == 16'd0 && rsp_data.arrival_out == 32'd0 &&
         rsp_data.waiting_out == 32'd0)
      else $error("statistics reported on a non-completion transaction");

endmodule

bind round_robin_task_scheduler_top rrts_checker u_rrts_checker (.*);

### verif/tb_round_robin_task_scheduler_top.sv
// Self-checking testbench for round_robin_task_scheduler_top: random req/rsp idling,
// time_quantum phases, and a scoreboard class that predicts every rsp transaction.
// Depends on rrts_pkg and the round_robin_task_scheduler_top RTL.
`timescale 1ns / 100ps

module tb_round_robin_task_scheduler_top;

   localparam int IDLE_LIMIT  = 4000;
   localparam int SETTLE_WAIT = 60;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 200;

   class sched_scoreboard;
      rrts_pkg::entry_type slot [rrts_pkg::QUEUE_DEPTH];
      int unsigned head;
      int unsigned tail;
      int unsigned count;
      bit          run_valid;
      rrts_pkg::entry_type run;
      logic [31:0] now;
      logic [15:0] quantum;
      rrts_pkg::rsp_type want_q [$];
      int unsigned errors;
      int unsigned items_seen;
      int unsigned event_seen [6];

      function new();
         head = 0;
         tail = 0;
         count = 0;
         run_valid = 1'b0;
         run = '0;
         now = '0;
         quantum = 16'd4;
         errors = 0;
         items_seen = 0;
         foreach (event_seen[i]) event_seen[i] = 0;
      endfunction

      function int unsigned pending();
         return want_q.size();
      endfunction

      function void enqueue(rrts_pkg::entry_type e);
         slot[tail] = e;
         tail = (tail + 1) % rrts_pkg::QUEUE_DEPTH;
         count++;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
         errors++;
      endtask

      function void note_input(rrts_pkg::req_type r);
         rrts_pkg::rsp_type   e;
         rrts_pkg::entry_type fresh;
         e = '0;
         items_seen++;
         if (r.mode == rrts_pkg::MODE_ADMIT) begin
            e.task_id_out = r.task_id;
            if (count >= rrts_pkg::QUEUE_DEPTH) begin
               e.event_res = rrts_pkg::EV_REJECTED;
            end else begin
               fresh.task_id   = r.task_id;
               fresh.remaining = r.burst;
               fresh.burst     = r.burst;
               fresh.arrival   = now + 32'd1;
               fresh.waiting   = '0;
               enqueue(fresh);
               e.event_res = rrts_pkg::EV_ADMITTED;
            end
         end else begin
            now = now + 32'd1;
            if (!run_valid && count == 0) begin
               e.event_res = rrts_pkg::EV_IDLE;
            end else begin
               if (!run_valid) begin
                  run = slot[head];
                  run_valid = 1'b1;
                  head = (head + 1) % rrts_pkg::QUEUE_DEPTH;
                  count--;
               end
               if (run.remaining != 0) run.remaining = run.remaining - 16'd1;
               for (int i = 0; i < count; i++) begin
                  int unsigned k;
                  k = (head + i) % rrts_pkg::QUEUE_DEPTH;
                  if (slot[k].waiting != 32'hFFFF_FFFF) slot[k].waiting = slot[k].waiting + 32'd1;
               end
               e.task_id_out = run.task_id;
               if (run.remaining == 0) begin
                  e.event_res   = rrts_pkg::EV_COMPLETE;
                  e.burst_out   = run.burst;
                  e.arrival_out = run.arrival;
                  e.waiting_out = run.waiting;
                  run_valid = 1'b0;
               end else if (quantum != 0 && (now % {16'd0, quantum}) == 0 &&
                            count != 0 && count < rrts_pkg::QUEUE_DEPTH) begin
                  enqueue(run);
                  run_valid = 1'b0;
                  e.event_res = rrts_pkg::EV_PREEMPT;
               end else begin
                  e.event_res = rrts_pkg::EV_RAN;
               end
            end
         end
         e.time_now    = now;
         e.ready_count = count[4:0];
         e.all_done    = (count == 0 && !run_valid);
         want_q.push_back(e);
      endfunction

      task check_result(rrts_pkg::rsp_type got);
         rrts_pkg::rsp_type want;
         if (want_q.size() == 0) begin
            report_mismatch("unexpected transaction", {29'd0, got.event_res}, 32'd0);
         end else begin
            want = want_q.pop_front();
            if (want.event_res <= rrts_pkg::EV_PREEMPT) event_seen[want.event_res]++;
            if (got.event_res !== want.event_res)
               report_mismatch("event_res", {29'd0, got.event_res}, {29'd0, want.event_res});
            if (got.task_id_out !== want.task_id_out)
               report_mismatch("task_id_out", {24'd0, got.task_id_out},
                               {24'd0, want.task_id_out});
            if (got.time_now !== want.time_now)
               report_mismatch("time_now", got.time_now, want.time_now);
            if (got.burst_out !== want.burst_out)
               report_mismatch("burst_out", {16'd0, got.burst_out}, {16'd0, want.burst_out});
            if (got.arrival_out !== want.arrival_out)
               report_mismatch("arrival_out", got.arrival_out, want.arrival_out);
            if (got.waiting_out !== want.waiting_out)
               report_mismatch("waiting_out", got.waiting_out, want.waiting_out);
            if (got.ready_count !== want.ready_count)
               report_mismatch("ready_count", {27'd0, got.ready_count},
                               {27'd0, want.ready_count});
            if (got.all_done !== want.all_done)
               report_mismatch("all_done", {31'd0, got.all_done}, {31'd0, want.all_done});
         end
      endtask
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   rrts_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   rrts_pkg::rsp_type rsp_data;
   logic        csr_write_en   = 1'b0;
   logic [15:0] csr_write_data = '0;

   sched_scoreboard sb = new();
   bit          quiet = 1'b0;
   int          stall_left = 0;
   int          stall_draw;
   int          idle_cycles = 0;

   always #2 clock = ~clock;

   round_robin_task_scheduler_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_input(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // hold rsp_stall for a drawn number of valid cycles per transaction
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         stall_draw = quiet ? 0 : $urandom_range(0, 4);
         stall_left <= stall_draw;
         rsp_stall  <= (stall_draw != 0);
      end else if (rsp_valid && rsp_stall) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
         $display("round_robin_task_scheduler_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic m, input logic [7:0] id, input logic [15:0] b);
      int      gap;
      rrts_pkg::req_type item;
      gap = quiet ? 0 : $urandom_range(0, 4);
      item.mode    = m;
      item.task_id = id;
      item.burst   = b;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [15:0] q);
      csr_write_en   <= 1'b1;
      csr_write_data <= q;
      sb.quantum = q;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // drop valid and wait for every outstanding rsp transaction
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   initial begin
      logic [15:0] quantum_plan [PHASES];
      int          admit_pct;
      logic        m;
      logic [15:0] b;
      quantum_plan = '{16'd3, 16'd0, 16'd2, 16'd65535, 16'd1, 16'd5, 16'd4, 16'd8, 16'd6};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_quantum(16'd1);
      send_item(rrts_pkg::MODE_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      send_item(rrts_pkg::MODE_ADMIT, 8'd255, 16'd3);
      send_item(rrts_pkg::MODE_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
      for (int i = 0; i < rrts_pkg::QUEUE_DEPTH; i++) begin
         send_item(rrts_pkg::MODE_ADMIT, (i == 0) ? 8'd0 : 8'($urandom_range(1, 254)),
                   (i == 0) ? 16'd0 : (i == 1) ? 16'd1 : 16'($urandom_range(1, 6)));
      end
      send_item(rrts_pkg::MODE_ADMIT, 8'hAA, 16'd3);
      repeat (3) send_item(rrts_pkg::MODE_TICK, 8'($urandom_range(0, 255)),
                           16'($urandom_range(0, 65535)));
      settle();

      for (int p = 0; p < PHASES; p++) begin
         write_quantum(quantum_plan[p]);
         case ($urandom_range(0, 2))
            0: begin
               admit_pct = 10;
            end
            1: begin
               admit_pct = 20;
            end
            default: begin
               admit_pct = 35;
            end
         endcase
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            m = ($urandom_range(0, 99) < admit_pct) ? rrts_pkg::MODE_ADMIT : rrts_pkg::MODE_TICK;
            b = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 64))
                                             : 16'($urandom_range(1, 12));
            send_item(m, 8'($urandom_range(0, 255)), b);
         end
         settle();
      end

      $display("Ran %0d transactions over %0d quantum settings incl. zero and 65535.",
               sb.items_seen, PHASES + 1);
      $display("Seen: %0d admitted, %0d rejected, %0d idle, %0d ran, %0d completed, %0d preempted",
               sb.event_seen[rrts_pkg::EV_ADMITTED], sb.event_seen[rrts_pkg::EV_REJECTED],
               sb.event_seen[rrts_pkg::EV_IDLE], sb.event_seen[rrts_pkg::EV_RAN],
               sb.event_seen[rrts_pkg::EV_COMPLETE], sb.event_seen[rrts_pkg::EV_PREEMPT]);
      if (sb.errors == 0) begin
         $display("round_robin_task_scheduler_top regression: pass");
      end else begin
         $display("round_robin_task_scheduler_top regression: fail");
      end
      $finish;
   end

endmodule
